/* hdl/sse_pkg.sv */
// Shared types, codes and constants for the string stack engine.
package sse_pkg;

  localparam int STACK_DEPTH_DEF = 1024;
  localparam int MAX_STRING_DEF  = 64;

  localparam int BYTE_W      = 8;
  localparam int COUNT_OUT_W = 11;
  localparam int S_TDATA_W   = 8;
  localparam int S_TUSER_W   = 2;
  localparam int M_TDATA_W   = 24;

  typedef enum logic [1:0] {
    OP_PUSH_BYTE,
    OP_POP_BYTE,
    OP_POP_STRING,
    OP_DROP_STRING
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_WAIT,
    ST_SCAN,
    ST_EMIT,
    ST_RESP
  } state_t;

endpackage

/* hdl/sse_ram.sv */
// Byte store of the stack: one write port and one registered read port.
module sse_ram
  import sse_pkg::*;
#(
  parameter int DEPTH = STACK_DEPTH_DEF,
  parameter int AW    = $clog2(STACK_DEPTH_DEF)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/string_stack_engine_core.sv */
// Top level of the string stack engine: control, stack pointers and output register.
//
//   Channel  Direction  Signals                        Payload
//   s_       in         tvalid tready tdata tuser      push_value, operation
//   m_       out        tvalid tready tdata tlast      out_byte, ok, string_count, empty_res, last
//
// An item is taken only in the idle state; one item is worked on at a time.
// Push and an operation refused without a search go straight to the result state; pop byte first waits for its read.
// Pop string and drop string first walk the store one byte per cycle from the top;
// pop string then sends one byte per cycle while the output is not stalled, each byte
// being a fresh read of the single read port, and drop then passes to its result state.
// A pop string that finds no terminator within MAX_STRING bytes is refused.
// Reset is synchronous; a stalled result holds the engine in place.
module string_stack_engine_core
  import sse_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int MAX_STRING  = MAX_STRING_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] push_value
  input  logic [S_TUSER_W-1:0] s_tuser,   // [1:0] operation
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] out_byte, [8] ok, [19:9] string_count,
                                          // [20] empty_res, [23:21] zero
  output logic                 m_tlast
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int FW = $clog2(STACK_DEPTH + 1);
  localparam int MW = $clog2(MAX_STRING + 1);
  localparam int LW = (FW > MW) ? FW : MW;
  localparam logic [FW-1:0] DEPTH_W = FW'(STACK_DEPTH);

  state_t state, state_next;

  logic [FW-1:0] free_slots;
  logic [FW-1:0] term_count;
  logic [FW-1:0] issue_cnt;
  logic [FW-1:0] check_cnt;
  logic [FW-1:0] scan_limit;
  logic [FW-1:0] str_len;
  logic [FW-1:0] emit_cnt;
  logic          rd_vld;
  logic          is_pop_str;
  logic [BYTE_W-1:0] resp_byte;
  logic          resp_ok;
  logic          str_empty;

  logic [BYTE_W-1:0]      out_byte;
  logic                   out_ok;
  logic                   out_last;
  logic [COUNT_OUT_W-1:0] out_count;
  logic                   out_empty;

  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr;
  logic [BYTE_W-1:0] mem_wr_data;
  logic              mem_rd_en;
  logic [AW-1:0]     mem_rd_addr;
  logic [BYTE_W-1:0] mem_rd_data;

  op_t           op_in;
  logic [BYTE_W-1:0] val_in;
  logic          accept;
  logic          is_empty;
  logic          is_full;
  logic [FW-1:0] held;
  logic [LW-1:0] held_l;
  logic [LW-1:0] lim_l;
  logic          out_free;
  logic          rd_zero;
  logic          scan_found;
  logic          scan_fail;
  logic          emit_last;
  logic          out_load;

  assign op_in    = op_t'(s_tuser);
  assign val_in   = s_tdata[BYTE_W-1:0];
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign is_empty = (free_slots == DEPTH_W);
  assign is_full  = (free_slots == '0);
  assign held     = DEPTH_W - free_slots;
  assign held_l   = LW'(held);
  assign lim_l    = (held_l < LW'(MAX_STRING)) ? held_l : LW'(MAX_STRING);
  assign out_free = !m_tvalid || m_tready;
  assign rd_zero  = (mem_rd_data == '0);
  assign scan_found = (state == ST_SCAN) && rd_vld && rd_zero;
  assign scan_fail  = (state == ST_SCAN) && rd_vld && !rd_zero &&
                      (FW'(check_cnt + 1'b1) == scan_limit);
  assign emit_last  = (FW'(emit_cnt + 1'b1) == str_len);

  sse_ram #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_in)
            OP_PUSH_BYTE:   state_next = ST_RESP;
            OP_POP_BYTE:    state_next = is_empty ? ST_RESP : ST_POP_WAIT;
            OP_POP_STRING,
            OP_DROP_STRING: state_next = (is_empty || term_count == '0) ? ST_RESP : ST_SCAN;
          endcase
        end
      end
      ST_POP_WAIT: state_next = ST_RESP;
      ST_SCAN: begin
        if (scan_found) begin
          state_next = is_pop_str ? ST_EMIT : ST_RESP;
        end else if (scan_fail) begin
          state_next = ST_RESP;
        end
      end
      ST_EMIT: begin
        if (out_free && emit_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = AW'(free_slots - 1'b1);
    mem_wr_data = val_in;
    mem_rd_en   = 1'b0;
    mem_rd_addr = AW'(free_slots);
    out_load    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept && op_in == OP_PUSH_BYTE && !is_full) begin
          mem_wr_en = 1'b1;
        end
        if (accept && op_in == OP_POP_BYTE && !is_empty) begin
          mem_rd_en = 1'b1;
        end
      end
      ST_POP_WAIT: ;
      ST_SCAN: begin
        mem_rd_en = 1'b1;
        if (!(scan_found && is_pop_str)) begin
          mem_rd_addr = AW'(free_slots + issue_cnt);
        end
      end
      ST_EMIT: begin
        out_load = out_free;
        if (out_free && !emit_last) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = AW'(free_slots + 1'b1);
        end
      end
      ST_RESP: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      free_slots <= DEPTH_W;
      term_count <= '0;
      rd_vld     <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= (state == ST_SCAN) && (state_next == ST_SCAN);
      case (state)
        ST_IDLE: begin
          if (accept) begin
            resp_byte  <= '0;
            resp_ok    <= 1'b0;
            is_pop_str <= (op_in == OP_POP_STRING);
            issue_cnt  <= '0;
            check_cnt  <= '0;
            emit_cnt   <= '0;
            scan_limit <= (op_in == OP_POP_STRING) ? FW'(lim_l) : held;
            if (op_in == OP_PUSH_BYTE && !is_full) begin
              resp_ok    <= 1'b1;
              free_slots <= FW'(free_slots - 1'b1);
              if (val_in == '0) begin
                term_count <= FW'(term_count + 1'b1);
              end
            end
            if (op_in == OP_POP_BYTE && !is_empty) begin
              resp_ok    <= 1'b1;
              free_slots <= FW'(free_slots + 1'b1);
            end
          end
        end
        ST_POP_WAIT: begin
          resp_byte <= mem_rd_data;
          if (rd_zero && term_count != '0) begin
            term_count <= FW'(term_count - 1'b1);
          end
        end
        ST_SCAN: begin
          issue_cnt <= FW'(issue_cnt + 1'b1);
          if (rd_vld && !rd_zero) begin
            check_cnt <= FW'(check_cnt + 1'b1);
          end
          if (scan_found) begin
            str_len    <= FW'(check_cnt + 1'b1);
            str_empty  <= (held == FW'(check_cnt + 1'b1));
            term_count <= FW'(term_count - 1'b1);
            resp_ok    <= 1'b1;
            if (!is_pop_str) begin
              free_slots <= FW'(free_slots + check_cnt + 1'b1);
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            free_slots <= FW'(free_slots + 1'b1);
            emit_cnt   <= FW'(emit_cnt + 1'b1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_count <= COUNT_OUT_W'(term_count);
      if (state == ST_EMIT) begin
        out_byte  <= mem_rd_data;
        out_ok    <= 1'b1;
        out_last  <= emit_last;
        out_empty <= str_empty;
      end else begin
        out_byte  <= resp_byte;
        out_ok    <= resp_ok;
        out_last  <= 1'b1;
        out_empty <= is_empty;
      end
    end
  end

  assign m_tdata = {3'b000, out_empty, out_count, out_ok, out_byte};
  assign m_tlast = out_last;

endmodule

/* bench/tb_top.sv */
// Testbench for the string stack engine: predicted byte stack, stream drivers and result checks.
`timescale 1ns / 100ps

module tb_top;
  import sse_pkg::*;

  localparam int DEPTH   = STACK_DEPTH_DEF;
  localparam int MAX_STR = MAX_STRING_DEF;

  typedef struct {
    logic [7:0]  out_byte;
    logic        ok;
    logic        last;
    logic [10:0] string_count;
    logic        empty_res;
  } result_t;

  class stack_scoreboard;
    logic [7:0] mem [DEPTH];
    int free_slots;
    int nul_count;
    int errors;
    result_t pending[$];
    result_t step_res[$];

    function new();
      free_slots = DEPTH;
      nul_count  = 0;
      errors     = 0;
    endfunction

    function int top_len(int limit);
      int held;
      int i;
      held = DEPTH - free_slots;
      for (i = 0; i < held && i < limit; i++) begin
        if (mem[free_slots + i] == 8'h00) return i + 1;
      end
      return 0;
    endfunction

    function void add(logic [7:0] b, logic okb, logic lastb);
      result_t r;
      r.out_byte     = b;
      r.ok           = okb;
      r.last         = lastb;
      r.string_count = '0;
      r.empty_res    = 1'b0;
      step_res.push_back(r);
    endfunction

    function void drop_nul();
      if (nul_count > 0) nul_count--;
    endfunction

    function void note_request(op_t op, logic [7:0] val);
      int len;
      int i;
      logic [7:0] ch;
      step_res.delete();
      case (op)
        OP_PUSH_BYTE: begin
          if (free_slots == 0) begin
            add(8'h00, 1'b0, 1'b1);
          end else begin
            free_slots--;
            mem[free_slots] = val;
            if (val == 8'h00) nul_count++;
            add(8'h00, 1'b1, 1'b1);
          end
        end
        OP_POP_BYTE: begin
          if (free_slots >= DEPTH) begin
            add(8'h00, 1'b0, 1'b1);
          end else begin
            ch = mem[free_slots];
            free_slots++;
            if (ch == 8'h00) drop_nul();
            add(ch, 1'b1, 1'b1);
          end
        end
        OP_POP_STRING: begin
          len = top_len(MAX_STR);
          if (len == 0) begin
            add(8'h00, 1'b0, 1'b1);
          end else begin
            for (i = 0; i < len; i++) add(mem[free_slots + i], 1'b1, i == len - 1);
            free_slots += len;
            drop_nul();
          end
        end
        default: begin
          len = top_len(DEPTH);
          if (len == 0) begin
            add(8'h00, 1'b0, 1'b1);
          end else begin
            free_slots += len;
            drop_nul();
            add(8'h00, 1'b1, 1'b1);
          end
        end
      endcase
      foreach (step_res[k]) begin
        step_res[k].string_count = nul_count[10:0];
        step_res[k].empty_res    = (free_slots >= DEPTH);
        pending.push_back(step_res[k]);
      end
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_response(logic [M_TDATA_W-1:0] data, logic tlast);
      result_t e;
      if (pending.size() == 0) begin
        $error("result transfer with nothing expected: tdata %h, tlast %b", data, tlast);
        errors++;
        return;
      end
      e = pending.pop_front();
      compare_field("out_byte", e.out_byte, data[7:0]);
      compare_field("ok", e.ok, data[8]);
      compare_field("string_count", e.string_count, data[19:9]);
      compare_field("empty_res", e.empty_res, data[20]);
      compare_field("pad", 0, data[23:21]);
      compare_field("last", e.last, tlast);
    endfunction
  endclass

  logic                 clk;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic [S_TUSER_W-1:0] s_tuser  = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;

  int src_idle = 20;
  int dst_idle = 59;
  int sent     = 0;

  stack_scoreboard sb = new();

  string_stack_engine_core #(
    .STACK_DEPTH(DEPTH),
    .MAX_STRING (MAX_STR)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= dst_idle);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_response(m_tdata, m_tlast);
  end

  // Entered and left just after a falling edge.
  task automatic send_item(input op_t op, input logic [7:0] val);
    while ($urandom_range(0, 99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= val;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(op, val);
    sent++;
    @(negedge clk);
  endtask

  task automatic push_string(input int len);
    send_item(OP_PUSH_BYTE, 8'h00);
    repeat (len) send_item(OP_PUSH_BYTE, 8'($urandom_range(1, 255)));
  endtask

  task automatic random_phase(input int count);
    int start;
    int r;
    int len;
    start = sent;
    while (sent - start < count) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        case ($urandom_range(0, 19))
          0:       len = $urandom_range(60, 70);
          1:       len = MAX_STR - 1;
          2:       len = MAX_STR;
          default: len = $urandom_range(0, 12);
        endcase
        if (sb.free_slots < len + 60) begin
          send_item(OP_DROP_STRING, 8'h00);
        end else begin
          push_string(len);
          r = $urandom_range(0, 9);
          if (r < 5) send_item(OP_POP_STRING, 8'h00);
          else if (r < 7) send_item(OP_DROP_STRING, 8'h00);
        end
      end else if (r < 75) begin
        send_item(OP_POP_STRING, 8'($urandom_range(0, 255)));
      end else if (r < 85) begin
        send_item(OP_DROP_STRING, 8'($urandom_range(0, 255)));
      end else if (r < 92) begin
        send_item(OP_POP_BYTE, 8'($urandom_range(0, 255)));
      end else begin
        send_item(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic clear_stack();
    while (sb.free_slots != DEPTH) begin
      if (sb.nul_count > 0) send_item(OP_DROP_STRING, 8'h00);
      else send_item(OP_POP_BYTE, 8'h00);
    end
    send_item(OP_PUSH_BYTE, 8'h00);
    send_item(OP_POP_STRING, 8'h00);
    send_item(OP_POP_BYTE, 8'h00);
    send_item(OP_PUSH_BYTE, 8'h00);
    send_item(OP_DROP_STRING, 8'h00);
    send_item(OP_DROP_STRING, 8'h00);
    send_item(OP_POP_BYTE, 8'h00);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_item(OP_POP_BYTE, 8'h00);
    send_item(OP_POP_STRING, 8'h00);
    send_item(OP_DROP_STRING, 8'h00);
    send_item(OP_PUSH_BYTE, 8'hFF);
    send_item(OP_POP_BYTE, 8'h00);
    send_item(OP_PUSH_BYTE, 8'h00);
    send_item(OP_PUSH_BYTE, 8'hAA);
    send_item(OP_PUSH_BYTE, 8'h55);
    send_item(OP_POP_STRING, 8'h00);
    send_item(OP_PUSH_BYTE, 8'h00);
    send_item(OP_PUSH_BYTE, 8'h01);
    send_item(OP_DROP_STRING, 8'h00);
    send_item(OP_PUSH_BYTE, 8'h80);
    send_item(OP_PUSH_BYTE, 8'h7F);
    send_item(OP_POP_STRING, 8'h00);
    send_item(OP_DROP_STRING, 8'h00);
    send_item(OP_POP_BYTE, 8'h00);
    send_item(OP_POP_BYTE, 8'h00);
    send_item(OP_PUSH_BYTE, 8'h00);
    send_item(OP_POP_BYTE, 8'h00);

    random_phase(145);
    src_idle = 59;
    dst_idle = 20;
    random_phase(145);
    src_idle = 0;
    dst_idle = 0;
    random_phase(145);
    clear_stack();

    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* sim.f */
hdl/sse_pkg.sv
hdl/sse_ram.sv
hdl/string_stack_engine_core.sv
bench/tb_top.sv
